### hw/rtl/aes128_pkg.sv
// Package for the AES-128 pipelined encryption engine: payload types, S-box,
// round constants and the round helper functions. No dependencies.
`timescale 1ns / 1ps
package aes128_pkg;

  localparam int unsigned NumRounds = 10;

  typedef struct packed {
    logic [63:0] key_hi;
    logic [63:0] key_lo;
    logic [63:0] block_hi;
    logic [63:0] block_lo;
  } aes_in_t;

  typedef struct packed {
    logic [63:0] cipher_hi;
    logic [63:0] cipher_lo;
  } aes_out_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7C, 8'h77, 8'h7B, 8'hF2, 8'h6B, 8'h6F, 8'hC5, 8'h30, 8'h01, 8'h67, 8'h2B,
    8'hFE, 8'hD7, 8'hAB, 8'h76, 8'hCA, 8'h82, 8'hC9, 8'h7D, 8'hFA, 8'h59, 8'h47, 8'hF0,
    8'hAD, 8'hD4, 8'hA2, 8'hAF, 8'h9C, 8'hA4, 8'h72, 8'hC0, 8'hB7, 8'hFD, 8'h93, 8'h26,
    8'h36, 8'h3F, 8'hF7, 8'hCC, 8'h34, 8'hA5, 8'hE5, 8'hF1, 8'h71, 8'hD8, 8'h31, 8'h15,
    8'h04, 8'hC7, 8'h23, 8'hC3, 8'h18, 8'h96, 8'h05, 8'h9A, 8'h07, 8'h12, 8'h80, 8'hE2,
    8'hEB, 8'h27, 8'hB2, 8'h75, 8'h09, 8'h83, 8'h2C, 8'h1A, 8'h1B, 8'h6E, 8'h5A, 8'hA0,
    8'h52, 8'h3B, 8'hD6, 8'hB3, 8'h29, 8'hE3, 8'h2F, 8'h84, 8'h53, 8'hD1, 8'h00, 8'hED,
    8'h20, 8'hFC, 8'hB1, 8'h5B, 8'h6A, 8'hCB, 8'hBE, 8'h39, 8'h4A, 8'h4C, 8'h58, 8'hCF,
    8'hD0, 8'hEF, 8'hAA, 8'hFB, 8'h43, 8'h4D, 8'h33, 8'h85, 8'h45, 8'hF9, 8'h02, 8'h7F,
    8'h50, 8'h3C, 8'h9F, 8'hA8, 8'h51, 8'hA3, 8'h40, 8'h8F, 8'h92, 8'h9D, 8'h38, 8'hF5,
    8'hBC, 8'hB6, 8'hDA, 8'h21, 8'h10, 8'hFF, 8'hF3, 8'hD2, 8'hCD, 8'h0C, 8'h13, 8'hEC,
    8'h5F, 8'h97, 8'h44, 8'h17, 8'hC4, 8'hA7, 8'h7E, 8'h3D, 8'h64, 8'h5D, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4F, 8'hDC, 8'h22, 8'h2A, 8'h90, 8'h88, 8'h46, 8'hEE, 8'hB8, 8'h14,
    8'hDE, 8'h5E, 8'h0B, 8'hDB, 8'hE0, 8'h32, 8'h3A, 8'h0A, 8'h49, 8'h06, 8'h24, 8'h5C,
    8'hC2, 8'hD3, 8'hAC, 8'h62, 8'h91, 8'h95, 8'hE4, 8'h79, 8'hE7, 8'hC8, 8'h37, 8'h6D,
    8'h8D, 8'hD5, 8'h4E, 8'hA9, 8'h6C, 8'h56, 8'hF4, 8'hEA, 8'h65, 8'h7A, 8'hAE, 8'h08,
    8'hBA, 8'h78, 8'h25, 8'h2E, 8'h1C, 8'hA6, 8'hB4, 8'hC6, 8'hE8, 8'hDD, 8'h74, 8'h1F,
    8'h4B, 8'hBD, 8'h8B, 8'h8A, 8'h70, 8'h3E, 8'hB5, 8'h66, 8'h48, 8'h03, 8'hF6, 8'h0E,
    8'h61, 8'h35, 8'h57, 8'hB9, 8'h86, 8'hC1, 8'h1D, 8'h9E, 8'hE1, 8'hF8, 8'h98, 8'h11,
    8'h69, 8'hD9, 8'h8E, 8'h94, 8'h9B, 8'h1E, 8'h87, 8'hE9, 8'hCE, 8'h55, 8'h28, 8'hDF,
    8'h8C, 8'hA1, 8'h89, 8'h0D, 8'hBF, 8'hE6, 8'h42, 8'h68, 8'h41, 8'h99, 8'h2D, 8'h0F,
    8'hB0, 8'h54, 8'hBB, 8'h16
  };

  localparam logic [7:0] RCON [NumRounds] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1B, 8'h36
  };

  localparam logic [7:0] GfPoly = 8'h1B;

  // Byte n of the 128-bit word sits in bits 127-8n downto 120-8n.
  function automatic logic [7:0] get_byte(logic [127:0] w, int unsigned n);
    get_byte = w[127 - 8 * n -: 8];
  endfunction

  function automatic logic [7:0] gf_dbl(logic [7:0] v);
    gf_dbl = {v[6:0], 1'b0} ^ (v[7] ? GfPoly : 8'h00);
  endfunction

  function automatic logic [127:0] next_key(logic [127:0] k, logic [7:0] rc);
    logic [31:0] t;
    logic [127:0] r;
    t = {SBOX[get_byte(k, 13)] ^ rc, SBOX[get_byte(k, 14)],
         SBOX[get_byte(k, 15)], SBOX[get_byte(k, 12)]};
    r[127:96] = k[127:96] ^ t;
    r[95:64]  = k[95:64] ^ r[127:96];
    r[63:32]  = k[63:32] ^ r[95:64];
    r[31:0]   = k[31:0] ^ r[63:32];
    next_key = r;
  endfunction

  function automatic logic [127:0] sub_shift(logic [127:0] s);
    logic [127:0] t;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        t[127 - 8 * (r + 4 * c) -: 8] = SBOX[get_byte(s, r + 4 * ((c + r) % 4))];
      end
    end
    sub_shift = t;
  endfunction

  function automatic logic [127:0] mix_cols(logic [127:0] s);
    logic [127:0] t;
    logic [7:0] a0, a1, a2, a3, all;
    for (int c = 0; c < 4; c++) begin
      a0 = get_byte(s, 4 * c);
      a1 = get_byte(s, 4 * c + 1);
      a2 = get_byte(s, 4 * c + 2);
      a3 = get_byte(s, 4 * c + 3);
      all = a0 ^ a1 ^ a2 ^ a3;
      t[127 - 32 * c -: 32] = {a0 ^ all ^ gf_dbl(a0 ^ a1), a1 ^ all ^ gf_dbl(a1 ^ a2),
                               a2 ^ all ^ gf_dbl(a2 ^ a3), a3 ^ all ^ gf_dbl(a3 ^ a0)};
    end
    mix_cols = t;
  endfunction

endpackage

### hw/rtl/aes128_round.sv
// One registered AES round stage: key expansion step plus state round.
// Depends on aes128_pkg.
`timescale 1ns / 1ps
module aes128_round
  import aes128_pkg::*;
#(
  parameter int unsigned Round = 0,
  parameter bit          Last  = 1'b0
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic         valid_i,
  input  logic [127:0] key_i,
  input  logic [127:0] state_i,
  output logic         valid_o,
  output logic [127:0] key_o,
  output logic [127:0] state_o
);

  logic [127:0] key_d, state_d, sb_d;
  logic         valid_q;
  logic [127:0] key_q, state_q;

  always_comb begin
    key_d = next_key(key_i, RCON[Round]);
    sb_d  = sub_shift(state_i);
    state_d = (Last ? sb_d : mix_cols(sb_d)) ^ key_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      key_q   <= key_d;
      state_q <= state_d;
    end
  end

  assign valid_o = valid_q;
  assign key_o   = key_q;
  assign state_o = state_q;

endmodule

### hw/rtl/aes128_block_encrypt.sv
// Top level of the pipelined AES-128 encryption engine.
// Depends on aes128_pkg and aes128_round.
//
//   channel | valid    | ready    | payload
//   input   | in_valid_i  | in_ready_o  | in_data_i  (aes_in_t)
//   output  | out_valid_o | out_ready_i | out_data_o (aes_out_t)
//
// One stage does the initial key addition, then there is one
// stage per round, ten in all. One block enters per cycle unless the pipeline holds.
// The whole pipeline advances together; it holds only while the last stage
// has a result that the output side does not take. Reset clears valid bits.
`timescale 1ns / 1ps
module aes128_block_encrypt
  import aes128_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  aes_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output aes_out_t out_data_o
);

  logic               adv;
  logic [NumRounds:0] valid;
  logic [127:0]       key   [NumRounds+1];
  logic [127:0]       state [NumRounds+1];
  logic               valid0_q;
  logic [127:0]       key0_q, state0_q;

  assign adv        = !valid[NumRounds] || out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid0_q <= 1'b0;
    end else if (adv) begin
      valid0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_valid_i) begin
      key0_q   <= {in_data_i.key_hi, in_data_i.key_lo};
      state0_q <= {in_data_i.block_hi, in_data_i.block_lo} ^
                  {in_data_i.key_hi, in_data_i.key_lo};
    end
  end

  assign valid[0] = valid0_q;
  assign key[0]   = key0_q;
  assign state[0] = state0_q;

  for (genvar g = 0; g < NumRounds; g++) begin : g_round
    aes128_round #(
      .Round(g),
      .Last (g == NumRounds - 1)
    ) u_round (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .valid_i(valid[g]),
      .key_i  (key[g]),
      .state_i(state[g]),
      .valid_o(valid[g+1]),
      .key_o  (key[g+1]),
      .state_o(state[g+1])
    );
  end

  assign out_valid_o          = valid[NumRounds];
  assign out_data_o.cipher_hi = state[NumRounds][127:64];
  assign out_data_o.cipher_lo = state[NumRounds][63:0];

endmodule
